### sv/assert_macros.svh
// Assertion helpers shared by the RTL. Both expect signals named clock and
// reset in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define ASSERT_HOLDS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// Check that a condition is followed in the next cycle by a consequence.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: text console writer shared definitions
// Screen geometry, character codes, microcode control word and the
// microprogram of the console sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;
   localparam int ADDR_W  = $clog2(CELLS);
   localparam int COL_W   = $clog2(COLUMNS);
   localparam int ROW_W   = (ROWS > 2) ? $clog2(ROWS) : 1;

   localparam int CMD_W  = 2;
   localparam int BYTE_W = 8;
   localparam int POS_W  = 11;
   localparam int CELL_W = 16;

   localparam logic [BYTE_W-1:0] ATTR_DEFAULT = 8'h07;
   localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
   localparam logic [CELL_W-1:0] BLANK_CELL   = {ATTR_DEFAULT, CH_SPACE};

   typedef enum logic [CMD_W-1:0] {
      CMD_PUT   = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   // microprogram step addresses
   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_PUT,
      S_NEWROW,
      S_BS_STEP,
      S_BS_READ,
      S_BS_WRITE,
      S_CLR,
      S_CLR_HOME,
      S_RD_ISSUE,
      S_RD_TAKE,
      S_SCR_PRIME,
      S_SCR_COPY,
      S_SCR_LAST,
      S_SCR_BLANK,
      S_RESP
   } step_type;

   typedef enum logic [2:0] {
      WR_NONE, WR_BLANK, WR_FILL, WR_PUT, WR_ERASE, WR_COPY
   } wr_src_type;

   typedef enum logic [1:0] {
      WA_CURSOR, WA_ADDR, WA_PREV
   } wr_addr_type;

   typedef enum logic [1:0] {
      RD_NONE, RD_CURSOR, RD_INDEX, RD_SCROLL
   } rd_sel_type;

   typedef enum logic [1:0] {
      ADDR_HOLD, ADDR_ZERO, ADDR_INC
   } addr_op_type;

   typedef enum logic [2:0] {
      CUR_HOLD, CUR_FWD, CUR_BACK, CUR_NEWLINE, CUR_HOME
   } cur_op_type;

   typedef enum logic [2:0] {
      C_NEVER, C_DISPATCH, C_MORE_ALL, C_MORE_COPY, C_COL_WRAP, C_ROW_LAST, C_RSP_BUSY
   } cond_type;

   typedef struct packed {
      logic        ready;
      wr_src_type  wr_src;
      wr_addr_type wr_addr;
      rd_sel_type  rd_sel;
      addr_op_type addr_op;
      cur_op_type  cur_op;
      logic        load_rd;
      logic        load_rsp;
      cond_type    cond;
      step_type    jump;
      step_type    seq;
   } uctl_type;

   typedef struct packed {
      logic    accept;
      cmd_type cmd;
      logic    is_newline;
      logic    is_backspace;
      logic    end_all;
      logic    end_copy;
      logic    col_last;
      logic    row_last;
      logic    rsp_busy;
   } stat_type;

   // Microprogram ROM: one control word per step. When cond is true the
   // sequencer takes jump (for the dispatch condition, the request's first step), otherwise seq.
   function automatic uctl_type uword(input step_type s);
      uctl_type w;
      w = '{ready: 1'b0, wr_src: WR_NONE, wr_addr: WA_ADDR, rd_sel: RD_NONE,
            addr_op: ADDR_HOLD, cur_op: CUR_HOLD, load_rd: 1'b0, load_rsp: 1'b0,
            cond: C_NEVER, jump: S_IDLE, seq: S_RESP};
      unique case (s)
         S_INIT: begin
            w.wr_src = WR_BLANK; w.addr_op = ADDR_INC;
            w.cond = C_MORE_ALL; w.jump = S_INIT; w.seq = S_IDLE;
         end
         S_IDLE: begin
            w.ready = 1'b1; w.addr_op = ADDR_ZERO;
            w.cond = C_DISPATCH; w.seq = S_IDLE;
         end
         S_PUT: begin
            w.wr_src = WR_PUT; w.wr_addr = WA_CURSOR; w.cur_op = CUR_FWD;
            w.cond = C_COL_WRAP; w.jump = S_NEWROW; w.seq = S_RESP;
         end
         S_NEWROW: begin
            w.addr_op = ADDR_ZERO; w.cur_op = CUR_NEWLINE;
            w.cond = C_ROW_LAST; w.jump = S_SCR_PRIME; w.seq = S_RESP;
         end
         S_BS_STEP: begin
            w.cur_op = CUR_BACK; w.seq = S_BS_READ;
         end
         S_BS_READ: begin
            w.rd_sel = RD_CURSOR; w.seq = S_BS_WRITE;
         end
         S_BS_WRITE: begin
            w.wr_src = WR_ERASE; w.wr_addr = WA_CURSOR; w.seq = S_RESP;
         end
         S_CLR: begin
            w.wr_src = WR_FILL; w.addr_op = ADDR_INC;
            w.cond = C_MORE_ALL; w.jump = S_CLR; w.seq = S_CLR_HOME;
         end
         S_CLR_HOME: begin
            w.cur_op = CUR_HOME; w.seq = S_RESP;
         end
         S_RD_ISSUE: begin
            w.rd_sel = RD_INDEX; w.seq = S_RD_TAKE;
         end
         S_RD_TAKE: begin
            w.load_rd = 1'b1; w.seq = S_RESP;
         end
         S_SCR_PRIME: begin
            w.rd_sel = RD_SCROLL; w.addr_op = ADDR_INC; w.seq = S_SCR_COPY;
         end
         S_SCR_COPY: begin
            w.rd_sel = RD_SCROLL; w.wr_src = WR_COPY; w.wr_addr = WA_PREV;
            w.addr_op = ADDR_INC;
            w.cond = C_MORE_COPY; w.jump = S_SCR_COPY; w.seq = S_SCR_LAST;
         end
         S_SCR_LAST: begin
            // hold the address: the blanking pass starts at the last row
            w.wr_src = WR_COPY; w.wr_addr = WA_PREV;
            w.seq = S_SCR_BLANK;
         end
         S_SCR_BLANK: begin
            w.wr_src = WR_BLANK; w.addr_op = ADDR_INC;
            w.cond = C_MORE_ALL; w.jump = S_SCR_BLANK; w.seq = S_RESP;
         end
         S_RESP: begin
            w.load_rsp = 1'b1;
            w.cond = C_RSP_BUSY; w.jump = S_RESP; w.seq = S_IDLE;
         end
         default: ;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

### sv/tcw_req_if.sv
// ----------------------------------------------------------------------------
// tcw_req_if: console request channel
// Valid/ready channel carrying one console command.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcw_req_if;
   import tcw_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [BYTE_W-1:0] char_code;
   logic [BYTE_W-1:0] fill_attr;
   logic              home_cursor;
   logic [POS_W-1:0]  cell_index;

   modport source (
      output valid, command, char_code, fill_attr, home_cursor, cell_index,
      input  ready
   );

   modport sink (
      input  valid, command, char_code, fill_attr, home_cursor, cell_index,
      output ready
   );
endinterface

`default_nettype wire

### sv/tcw_rsp_if.sv
// ----------------------------------------------------------------------------
// tcw_rsp_if: console response channel
// Valid/ready channel carrying cursor position and read cell data.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcw_rsp_if;
   import tcw_pkg::*;

   logic              valid;
   logic              ready;
   logic [POS_W-1:0]  cursor_pos;
   logic [BYTE_W-1:0] read_char;
   logic [BYTE_W-1:0] read_attr;

   modport source (
      output valid, cursor_pos, read_char, read_attr,
      input  ready
   );

   modport sink (
      input  valid, cursor_pos, read_char, read_attr,
      output ready
   );
endinterface

`default_nettype wire

### sv/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

`default_nettype wire

### sv/tcw_sequencer.sv
// ----------------------------------------------------------------------------
// tcw_sequencer: console microcode sequencer
// Step counter, microprogram ROM and conditional next-step selection.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_sequencer (
   input  logic              clock,
   input  logic              reset,
   input  tcw_pkg::stat_type stat,
   output tcw_pkg::uctl_type ctl
);
   import tcw_pkg::*;

   step_type step_ff;
   step_type step_in;
   step_type dispatch;
   logic     take_jump;

   always_comb begin
      ctl = uword(step_ff);

      // decode an accepted request into its first step
      unique case (stat.cmd)
         CMD_PUT: begin
            priority if (stat.is_newline) begin
               dispatch = S_NEWROW;
            end else if (stat.is_backspace) begin
               dispatch = S_BS_STEP;
            end else begin
               dispatch = S_PUT;
            end
         end
         CMD_CLEAR: dispatch = S_CLR;
         CMD_READ:  dispatch = S_RD_ISSUE;
         CMD_NOP:   dispatch = S_RESP;
         default:   dispatch = S_RESP;
      endcase

      unique case (ctl.cond)
         C_NEVER:     take_jump = 1'b0;
         C_DISPATCH:  take_jump = stat.accept;
         C_MORE_ALL:  take_jump = !stat.end_all;
         C_MORE_COPY: take_jump = !stat.end_copy;
         C_COL_WRAP:  take_jump = stat.col_last;
         C_ROW_LAST:  take_jump = stat.row_last;
         C_RSP_BUSY:  take_jump = stat.rsp_busy;
         default:     take_jump = 1'b0;
      endcase

      if (!take_jump) begin
         step_in = ctl.seq;
      end else if (ctl.cond == C_DISPATCH) begin
         step_in = dispatch;
      end else begin
         step_in = ctl.jump;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_INIT;
      end else begin
         step_ff <= step_in;
      end
   end
endmodule

`default_nettype wire

### sv/text_console_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_writer_unit: character-cell text console
// 80x25 screen store with cursor, driven by a small microprogram.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one command per request: put a character (newline and
//   backspace are control codes), clear the screen with a fill cell, or read
//   one cell. rsp_ch returns exactly one response per request, giving the
//   linear cursor position and, for a read, the cell's character/attribute.
//   Each request runs from the accept cycle to the response step; the
//   response is valid in the cycle after that step loads it. A put or
//   newline past the last row adds a scroll, one cell copied per cycle
//   through the store; clear writes one cell per cycle.
//   A new request is taken once the previous one has produced its response;
//   the response waits in an output register, so one more request can be
//   worked on while the receiver stalls. A full output register holds the
//   sequencer in its response step until the receiver takes the response.
//   Reset: synchronous. Afterwards the store is swept to space/attribute 07
//   with req_ch.ready low; cursor goes home.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module text_console_writer_unit (
   input  logic       clock,
   input  logic       reset,
   tcw_req_if.sink    req_ch,
   tcw_rsp_if.source  rsp_ch
);
   import tcw_pkg::*;

   uctl_type ctl;
   stat_type stat;

   // screen store port signals
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [CELL_W-1:0] ram_wdata;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_raddr;
   logic [CELL_W-1:0] ram_rdata;

   // sweep address and cursor
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ADDR_W-1:0] cur_cell;

   // latched request
   logic [BYTE_W-1:0] char_ff, char_in;
   logic [BYTE_W-1:0] attr_ff, attr_in;
   logic              home_ff, home_in;
   logic [POS_W-1:0]  index_ff, index_in;
   logic              index_ok;

   // read result and output register
   logic [BYTE_W-1:0] rd_char_ff, rd_char_in;
   logic [BYTE_W-1:0] rd_attr_ff, rd_attr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic [BYTE_W-1:0] rsp_char_ff, rsp_char_in;
   logic [BYTE_W-1:0] rsp_attr_ff, rsp_attr_in;
   logic              rsp_load;
   logic              req_accept;

   tcw_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctl   (ctl)
   );

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_ch.ready = ctl.ready;
   assign req_accept   = req_ch.valid && ctl.ready;

   assign cur_cell = ADDR_W'(row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(col_ff);
   assign index_ok = 32'(index_ff) < 32'(CELLS);

   // status flags for the sequencer's jumps
   always_comb begin
      stat.accept       = req_accept;
      stat.cmd          = cmd_type'(req_ch.command);
      stat.is_newline   = req_ch.char_code == CH_NEWLINE;
      stat.is_backspace = req_ch.char_code == CH_BACKSPACE;
      stat.end_all      = addr_ff == ADDR_W'(CELLS - 1);
      stat.end_copy     = addr_ff == ADDR_W'(CELLS - COLUMNS - 1);
      stat.col_last     = col_ff == COL_W'(COLUMNS - 1);
      stat.row_last     = row_ff == ROW_W'(ROWS - 1);
      stat.rsp_busy     = rsp_valid_ff && !rsp_ch.ready;
   end

   // screen store write and read port
   always_comb begin
      ram_we = ctl.wr_src != WR_NONE;

      unique case (ctl.wr_addr)
         WA_CURSOR: ram_waddr = cur_cell;
         WA_ADDR:   ram_waddr = addr_ff;
         WA_PREV:   ram_waddr = addr_ff - ADDR_W'(1);   // copy writes behind its read, at the previous address
         default:   ram_waddr = addr_ff;
      endcase

      unique case (ctl.wr_src)
         WR_BLANK: ram_wdata = BLANK_CELL;
         WR_FILL:  ram_wdata = {attr_ff, char_ff};
         WR_PUT:   ram_wdata = {ATTR_DEFAULT, char_ff};
         WR_ERASE: ram_wdata = {ram_rdata[CELL_W-1:BYTE_W], CH_SPACE};  // keep attribute
         WR_COPY:  ram_wdata = ram_rdata;
         default:  ram_wdata = BLANK_CELL;
      endcase

      unique case (ctl.rd_sel)
         RD_CURSOR: begin
            ram_re    = 1'b1;
            ram_raddr = cur_cell;
         end
         RD_INDEX: begin
            // skip reads past the screen; they answer zero
            ram_re    = index_ok;
            ram_raddr = ADDR_W'(index_ff);
         end
         RD_SCROLL: begin
            // fetch the cell one row below the one it will be copied into
            ram_re    = 1'b1;
            ram_raddr = addr_ff + ADDR_W'(COLUMNS);
         end
         default: begin
            ram_re    = 1'b0;
            ram_raddr = addr_ff;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      addr_in     = addr_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      char_in     = char_ff;
      attr_in     = attr_ff;
      home_in     = home_ff;
      index_in    = index_ff;
      rd_char_in  = rd_char_ff;
      rd_attr_in  = rd_attr_ff;
      rsp_pos_in  = rsp_pos_ff;
      rsp_char_in = rsp_char_ff;
      rsp_attr_in = rsp_attr_ff;

      unique case (ctl.addr_op)
         ADDR_ZERO: addr_in = '0;
         ADDR_INC:  addr_in = addr_ff + ADDR_W'(1);
         default:   addr_in = addr_ff;
      endcase

      unique case (ctl.cur_op)
         CUR_FWD: begin
            // wrap the column here; the newline step then advances the row
            col_in = stat.col_last ? '0 : col_ff + COL_W'(1);
         end
         CUR_BACK: begin
            if (col_ff != '0) begin
               col_in = col_ff - COL_W'(1);
            end
         end
         CUR_NEWLINE: begin
            // on the last row stay put; the scroll makes room
            col_in = '0;
            if (!stat.row_last) begin
               row_in = row_ff + ROW_W'(1);
            end
         end
         CUR_HOME: begin
            if (home_ff) begin
               row_in = '0;
               col_in = '0;
            end
         end
         default: ;
      endcase

      // capture the request fields the microprogram needs later
      if (req_accept) begin
         char_in    = req_ch.char_code;
         attr_in    = req_ch.fill_attr;
         home_in    = req_ch.home_cursor;
         index_in   = req_ch.cell_index;
         rd_char_in = '0;
         rd_attr_in = '0;
      end

      if (ctl.load_rd) begin
         rd_char_in = index_ok ? ram_rdata[BYTE_W-1:0] : '0;
         rd_attr_in = index_ok ? ram_rdata[CELL_W-1:BYTE_W] : '0;
      end

      // load the output register only when it is free or being drained
      rsp_load = ctl.load_rsp && !stat.rsp_busy;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_pos_in   = POS_W'(cur_cell);
         rsp_char_in  = rd_char_ff;
         rsp_attr_in  = rd_attr_ff;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      char_ff     <= char_in;
      attr_ff     <= attr_in;
      home_ff     <= home_in;
      index_ff    <= index_in;
      rd_char_ff  <= rd_char_in;
      rd_attr_ff  <= rd_attr_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_char_ff <= rsp_char_in;
      rsp_attr_ff <= rsp_attr_in;
      if (reset) begin
         addr_ff      <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         addr_ff      <= addr_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.cursor_pos = rsp_pos_ff;
   assign rsp_ch.read_char  = rsp_char_ff;
   assign rsp_ch.read_attr  = rsp_attr_ff;

   // cursor never leaves the screen, not even between wrap and newline
   `ASSERT_HOLDS(a_cursor_on_screen, (32'(col_ff) < 32'(COLUMNS)) && (32'(row_ff) < 32'(ROWS)), "cursor off screen")
   // every accepted request leaves the idle step
   `ASSERT_NEXT(a_accept_leaves_idle, req_accept, !ctl.ready, "request accepted without dispatch")
   // scroll copy writes only above the last row
   `ASSERT_HOLDS(a_copy_in_bounds, (ctl.wr_src != WR_COPY) || ((addr_ff != '0) && (addr_ff <= ADDR_W'(CELLS - COLUMNS))), "scroll copy out of range")

endmodule

`default_nettype wire

### bench/text_console_writer_check.sv
// ----------------------------------------------------------------------------
// text_console_writer_check: console response checker
// Watches both console channels, keeps its own copy of the screen and the
// cursor, predicts one response per accepted request and compares every
// accepted response with the oldest prediction.
// ----------------------------------------------------------------------------

module text_console_writer_check (
   input  logic clock,
   input  logic reset,
   tcw_req_if   req_ch,
   tcw_rsp_if   rsp_ch,
   output int   errors,
   output int   waiting,
   output int   checked,
   output int   scrolls,
   output int   clears
);
   import tcw_pkg::*;

   localparam int REPORT_LIMIT = 100;

   typedef struct packed {
      logic [POS_W-1:0]  cursor_pos;
      logic [BYTE_W-1:0] read_char;
      logic [BYTE_W-1:0] read_attr;
   } console_reply_t;

   logic [CELL_W-1:0] screen [CELLS];
   int unsigned       cur_row;
   int unsigned       cur_col;
   console_reply_t    due_replies [$];

   initial begin
      errors  = 0;
      waiting = 0;
      checked = 0;
      scrolls = 0;
      clears  = 0;
   end

   // Move to column 0 of the next row; scroll the screen when past the bottom.
   function automatic void start_next_row();
      cur_col = 0;
      cur_row++;
      if (cur_row >= ROWS) begin
         for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
         for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = BLANK_CELL;
         cur_row = ROWS - 1;
         scrolls++;
      end
   endfunction

   function automatic console_reply_t apply_console_command(
      input cmd_type           cmd,
      input logic [BYTE_W-1:0] glyph,
      input logic [BYTE_W-1:0] attr,
      input logic              home,
      input logic [POS_W-1:0]  index
   );
      console_reply_t reply;
      int unsigned    spot;
      reply = '0;
      case (cmd)
         CMD_PUT: begin
            if (glyph == CH_NEWLINE) begin
               start_next_row();
            end else if (glyph == CH_BACKSPACE) begin
               if (cur_col > 0) cur_col--;
               spot = cur_row * COLUMNS + cur_col;
               screen[spot][BYTE_W-1:0] = CH_SPACE;
            end else begin
               spot = cur_row * COLUMNS + cur_col;
               screen[spot] = {ATTR_DEFAULT, glyph};
               cur_col++;
               if (cur_col >= COLUMNS) start_next_row();
            end
         end
         CMD_CLEAR: begin
            for (int i = 0; i < CELLS; i++) screen[i] = {attr, glyph};
            if (home) begin
               cur_row = 0;
               cur_col = 0;
            end
            clears++;
         end
         CMD_READ: begin
            if (index < CELLS) begin
               reply.read_char = screen[index][BYTE_W-1:0];
               reply.read_attr = screen[index][CELL_W-1:BYTE_W];
            end
         end
         default: ;
      endcase
      reply.cursor_pos = POS_W'(cur_row * COLUMNS + cur_col);
      return reply;
   endfunction

   function automatic void compare_field(input string label, input int want, input logic [31:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
      end
   endfunction

   always @(posedge clock) begin
      console_reply_t want;
      if (reset) begin
         for (int i = 0; i < CELLS; i++) screen[i] = BLANK_CELL;
         cur_row = 0;
         cur_col = 0;
         due_replies.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (due_replies.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("%0t: response with none expected, expected nothing, got pos %0d",
                           $time, rsp_ch.cursor_pos);
            end else begin
               want = due_replies.pop_front();
               compare_field("cursor_pos", want.cursor_pos, 32'(rsp_ch.cursor_pos));
               compare_field("read_char", want.read_char, 32'(rsp_ch.read_char));
               compare_field("read_attr", want.read_attr, 32'(rsp_ch.read_attr));
               checked++;
            end
         end
         if (req_ch.valid && req_ch.ready)
            due_replies.push_back(apply_console_command(cmd_type'(req_ch.command),
               req_ch.char_code, req_ch.fill_attr, req_ch.home_cursor, req_ch.cell_index));
      end
      waiting = due_replies.size();
   end

endmodule

### bench/text_console_writer_unit_test.sv
// ----------------------------------------------------------------------------
// text_console_writer_unit_test: text console testbench
// Drives console requests with random gaps, stalls the response side at
// random and once for a long stretch, and leaves every prediction and
// comparison to the checker that sits beside the console.
// ----------------------------------------------------------------------------

module text_console_writer_unit_test;
   import tcw_pkg::*;

   localparam int REQUEST_TARGET = 1550;
   localparam int LONG_HOLD      = 300;
   // Slowest legal run: every request a full-screen walk plus worst gap and
   // worst stall, then taken several times over.
   localparam int TIMEOUT_CYCLES = 20_000_000;
   localparam int SETTLE_CYCLES  = 64;

   logic clock = 1'b0;
   logic reset;

   int errors;
   int waiting;
   int checked;
   int scrolls;
   int clears;
   int sent = 0;
   int cycle_count = 0;

   bit sender_calm   = 1'b0;
   bit receiver_calm = 1'b0;
   bit long_hold     = 1'b0;

   tcw_req_if req_ch ();
   tcw_rsp_if rsp_ch ();

   text_console_writer_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   text_console_writer_check i_check (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .errors  (errors),
      .waiting (waiting),
      .checked (checked),
      .scrolls (scrolls),
      .clears  (clears)
   );

   always #1 clock = ~clock;

   // Abort a hung run.
   initial begin
      while (cycle_count < TIMEOUT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("text_console_writer_unit_test: errors");
      $finish;
   end

   // Pick a sender gap: mostly none or short, now and then long.
   function automatic int sender_gap();
      int r;
      if (sender_calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Response side: random stalls, calm stretches, and one long hold-off
   // on request from the stimulus. Change ready only at the falling edge.
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_ch.ready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            long_hold = 1'b0;
         end else if (!receiver_calm && $urandom_range(0, 2) == 0) begin
            stall = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(12, 60);
            rsp_ch.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         @(negedge clock);
      end
   end

   // Offer one request at a falling edge and hold it until accepted; then
   // drop valid for a random gap, or leave it up for the next request.
   task automatic send_request(
      input cmd_type           cmd,
      input logic [BYTE_W-1:0] glyph,
      input logic [BYTE_W-1:0] attr,
      input logic              home,
      input logic [POS_W-1:0]  index
   );
      int gap;
      req_ch.valid       = 1'b1;
      req_ch.command     = cmd;
      req_ch.char_code   = glyph;
      req_ch.fill_attr   = attr;
      req_ch.home_cursor = home;
      req_ch.cell_index  = index;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      sent++;
      gap = sender_gap();
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Put a character; the unused fields carry random junk.
   task automatic type_char(input logic [BYTE_W-1:0] glyph);
      send_request(CMD_PUT, glyph, BYTE_W'($urandom), 1'($urandom), POS_W'($urandom));
   endtask

   task automatic read_cell(input int index);
      send_request(CMD_READ, BYTE_W'($urandom), BYTE_W'($urandom), 1'($urandom), POS_W'(index));
   endtask

   task automatic clear_screen(input logic [BYTE_W-1:0] glyph, input logic [BYTE_W-1:0] attr,
                               input logic home);
      send_request(CMD_CLEAR, glyph, attr, home, POS_W'($urandom));
   endtask

   // Drop valid at a falling edge and hold off until every predicted
   // response is back.
   task automatic wait_for_replies();
      req_ch.valid = 1'b0;
      while (waiting != 0) @(negedge clock);
   endtask

   initial begin
      int pick;
      int len;
      int r;
      logic [BYTE_W-1:0] glyph;

      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.command     = CMD_PUT;
      req_ch.char_code   = '0;
      req_ch.fill_attr   = '0;
      req_ch.home_cursor = 1'b0;
      req_ch.cell_index  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: read the reset screen at both ends and past the end,
      // the unused command, puts of edge bytes, backspace mid-row and at
      // column 0, newline, clear with and without homing the cursor.
      read_cell(0);
      read_cell(CELLS - 1);
      read_cell(CELLS);
      read_cell(2**POS_W - 1);
      send_request(CMD_NOP, 8'hFF, 8'hFF, 1'b1, '1);
      type_char(8'h41);
      type_char(8'hFF);
      type_char(8'h00);
      type_char(CH_BACKSPACE);
      read_cell(2);
      read_cell(1);
      type_char(CH_NEWLINE);
      type_char(CH_BACKSPACE);
      type_char(8'h7E);
      read_cell(COLUMNS);
      clear_screen(8'hFF, 8'hFF, 1'b0);
      read_cell(0);
      read_cell(CELLS - 1);
      type_char(CH_SPACE);
      clear_screen(8'h00, 8'h00, 1'b1);
      read_cell(CELLS - 1);
      type_char(CH_BACKSPACE);
      read_cell(0);
      send_request(CMD_NOP, 8'h00, 8'h00, 1'b0, '0);

      // Pressure: the receiver holds off for a long stretch while the
      // sender keeps offering back to back, so the console fills and
      // stalls its request side. Then pause until everything is back.
      sender_calm = 1'b1;
      long_hold   = 1'b1;
      repeat (16) type_char(BYTE_W'($urandom_range(8'h21, 8'h7E)));
      wait_for_replies();

      // Random: mostly lines of text (wraps, scrolls, backspaces), then
      // reads, runs of newlines to reach the bottom row, clears and noise.
      while (sent < REQUEST_TARGET) begin
         sender_calm   = ($urandom_range(0, 4) == 0);
         receiver_calm = ($urandom_range(0, 4) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 68) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(81, 170) : $urandom_range(0, 60);
            repeat (len) begin
               if ($urandom_range(0, 11) == 0) begin
                  type_char(CH_BACKSPACE);
               end else begin
                  do glyph = BYTE_W'($urandom); while (glyph == CH_NEWLINE || glyph == CH_BACKSPACE);
                  type_char(glyph);
               end
            end
            if ($urandom_range(0, 5) != 0) type_char(CH_NEWLINE);
         end else if (pick < 84) begin
            repeat ($urandom_range(1, 4)) begin
               r = $urandom_range(0, 9);
               if (r == 0)
                  read_cell($urandom_range(CELLS, 2**POS_W - 1));
               else if (r < 5)
                  read_cell($urandom_range(CELLS - COLUMNS, CELLS - 1));
               else
                  read_cell($urandom_range(0, CELLS - 1));
            end
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 30)) type_char(CH_NEWLINE);
         end else if (pick < 95) begin
            clear_screen(BYTE_W'($urandom), BYTE_W'($urandom), 1'($urandom));
         end else begin
            repeat ($urandom_range(1, 3))
               send_request(CMD_NOP, BYTE_W'($urandom), BYTE_W'($urandom), 1'($urandom),
                            POS_W'($urandom));
         end
         // Now and then drain completely before going on.
         if ($urandom_range(0, 7) == 0) wait_for_replies();
      end

      // Drain, then watch a little longer for any stray response.
      req_ch.valid  = 1'b0;
      receiver_calm = 1'b0;
      wait_for_replies();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Sent %0d console requests and checked %0d responses.", sent, checked);
      $display("Screen walks predicted: %0d scrolls, %0d clears.", scrolls, clears);
      if (errors == 0) begin
         $display("text_console_writer_unit_test: clean");
      end else begin
         $display("text_console_writer_unit_test: errors");
      end
      $finish;
   end

endmodule
